/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on nothing; every macro takes its clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed: expr");

// Checks that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

`endif

/* sv/egbw_pkg.sv */
// Shared types and constants of the Exp-Golomb bitstream writer.
// Used by egbw_ctrl, egbw_dp and the top level; depends on nothing.
package egbw_pkg;

    // Request kinds carried on the input tuser field.
    localparam logic [2:0] KIND_START = 3'd0;
    localparam logic [2:0] KIND_FIXED = 3'd1;
    localparam logic [2:0] KIND_UE    = 3'd2;
    localparam logic [2:0] KIND_SE    = 3'd3;
    localparam logic [2:0] KIND_TRAIL = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_unit;
        logic load_fixed;
        logic load_code;
        logic code_signed;
        logic norm_en;
        logic emit_en;
        logic trail_en;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic norm_done;
        logic emit_done;
        logic out_free;
    } dp_sts_t;

endpackage

/* sv/egbw_ctrl.sv */
// Controller state machine of the Exp-Golomb bitstream writer.
// Depends on egbw_pkg for request kinds and the command/status structs.
module egbw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2:0]          kind,
    input  egbw_pkg::dp_sts_t   sts,
    output egbw_pkg::dp_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_NORM  = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam logic [1:0] ST_TRAIL = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (kind)
                        egbw_pkg::KIND_START: begin
                            cmd.clr_unit = 1'b1;
                        end
                        egbw_pkg::KIND_FIXED: begin
                            cmd.load_fixed = 1'b1;
                            state_next     = ST_EMIT;
                        end
                        egbw_pkg::KIND_UE: begin
                            cmd.load_code = 1'b1;
                            state_next    = ST_NORM;
                        end
                        egbw_pkg::KIND_SE: begin
                            cmd.load_code   = 1'b1;
                            cmd.code_signed = 1'b1;
                            state_next      = ST_NORM;
                        end
                        egbw_pkg::KIND_TRAIL: begin
                            state_next = ST_TRAIL;
                        end
                        default: begin
                            // Unused kinds are dropped without effect.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NORM: begin
                cmd.norm_en = 1'b1;
                if (sts.norm_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit_en = 1'b1;
                if (sts.emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TRAIL: begin
                cmd.trail_en = 1'b1;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/egbw_dp.sv */
// Datapath of the Exp-Golomb bitstream writer: bit packer, code
// normalizer, byte limit and output register. Depends on egbw_pkg.
module egbw_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic [5:0]          bit_count,
    input  logic [31:0]         value,
    input  logic [31:0]         signed_value,
    input  egbw_pkg::dp_cmd_t   cmd,
    output egbw_pkg::dp_sts_t   sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);

    // Leading zeros of a nonzero byte.
    function automatic logic [2:0] lead_zeros(input logic [7:0] b);
        logic [2:0] n;
        logic       found;
        n     = 3'd0;
        found = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!found && !b[i]) begin
                n = n + 3'd1;
            end else begin
                found = 1'b1;
            end
        end
        return n;
    endfunction

    logic [15:0] limit_reg, limit_next;
    logic [7:0]  partial_reg, partial_next;
    logic [3:0]  free_reg, free_next;
    logic [15:0] bytes_reg, bytes_next;
    logic [5:0]  zcnt_reg, zcnt_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic [31:0] data_reg, data_next;
    logic [5:0]  len_reg, len_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        ovalid_reg, ovalid_next;
    logic        olast_reg, olast_next;
    logic        odone_reg, odone_next;
    logic [15:0] ocount_reg, ocount_next;

    logic        pos;
    logic [31:0] dbl;
    logic [31:0] code_in;
    logic [2:0]  lz;
    logic [5:0]  len_eff;
    logic        limit_hit;
    logic        no_bits;
    logic        out_free;
    logic        push;
    logic [3:0]  k;
    logic [3:0]  left;
    logic [7:0]  fill;
    logic [6:0]  rem;
    logic [16:0] bytes_inc;

    // Exp-Golomb code word: v+1 for ue, mapped value plus one for se.
    assign pos     = (signed_value != 32'd0) && !signed_value[31];
    assign dbl     = {signed_value[30:0], 1'b0};
    assign code_in = cmd.code_signed ? (pos ? dbl : (~dbl + 32'd2)) : (value + 32'd1);

    assign lz        = lead_zeros(data_reg[31:24]);
    assign limit_hit = (bytes_reg >= limit_reg);
    assign no_bits   = (zcnt_reg == 6'd0) && (dcnt_reg == 6'd0);
    assign out_free  = !m_valid_reg || m_tready;
    assign bytes_inc = {1'b0, bytes_reg} + 17'd1;

    assign sts.norm_done = (data_reg[31:24] != 8'd0) || (len_reg == 6'd8);
    assign sts.emit_done = limit_hit || no_bits;
    assign sts.out_free  = out_free;

    always_comb begin
        limit_next   = cfg_wr_en ? cfg_wr_data : limit_reg;
        partial_next = partial_reg;
        free_next    = free_reg;
        bytes_next   = bytes_reg;
        zcnt_next    = zcnt_reg;
        dcnt_next    = dcnt_reg;
        data_next    = data_reg;
        len_next     = len_reg;
        push         = 1'b0;
        obyte_next   = obyte_reg;
        ovalid_next  = ovalid_reg;
        olast_next   = olast_reg;
        odone_next   = odone_reg;
        ocount_next  = ocount_reg;
        len_eff      = len_reg - {3'd0, lz};
        k            = 4'd0;
        left         = free_reg;
        fill         = partial_reg;
        rem          = 7'd0;

        if (cmd.clr_unit) begin
            partial_next = 8'd0;
            free_next    = 4'd8;
            bytes_next   = 16'd0;
        end

        if (cmd.load_fixed) begin
            if (bit_count > 6'd32) begin
                // Zero extension comes first, then all 32 value bits.
                zcnt_next = bit_count - 6'd32;
                dcnt_next = 6'd32;
                data_next = value;
            end else begin
                zcnt_next = 6'd0;
                dcnt_next = bit_count;
                data_next = value << (6'd32 - bit_count);
            end
        end

        if (cmd.load_code) begin
            data_next = code_in;
            len_next  = 6'd32;
            zcnt_next = 6'd0;
            dcnt_next = 6'd0;
        end

        // Normalize the code word a byte at a time, then by the
        // leading zeros of the top byte. A zero code writes nothing.
        if (cmd.norm_en) begin
            if (data_reg[31:24] == 8'd0) begin
                if (len_reg != 6'd8) begin
                    data_next = data_reg << 8;
                    len_next  = len_reg - 6'd8;
                end
            end else begin
                data_next = data_reg << lz;
                dcnt_next = len_eff;
                zcnt_next = len_eff - 6'd1;
            end
        end

        // Fill the partial byte with as many bits as it has room for.
        if (cmd.emit_en && out_free && !sts.emit_done) begin
            if (zcnt_reg != 6'd0) begin
                k         = (zcnt_reg < {2'd0, free_reg}) ? zcnt_reg[3:0] : free_reg;
                zcnt_next = zcnt_reg - {2'd0, k};
                rem       = {1'b0, zcnt_next} + {1'b0, dcnt_reg};
            end else begin
                k         = (dcnt_reg < {2'd0, free_reg}) ? dcnt_reg[3:0] : free_reg;
                dcnt_next = dcnt_reg - {2'd0, k};
                data_next = data_reg << k;
                fill      = partial_reg | (data_reg[31:24] >> (4'd8 - free_reg));
                rem       = {1'b0, dcnt_next};
            end
            left = free_reg - k;
            if (left == 4'd0) begin
                push         = 1'b1;
                obyte_next   = fill;
                ovalid_next  = 1'b1;
                odone_next   = 1'b0;
                ocount_next  = 16'd0;
                // Last byte of the request when too few bits remain for
                // another byte or this byte reaches the limit.
                olast_next   = (rem < 7'd8) || (bytes_inc >= {1'b0, limit_reg});
                partial_next = 8'd0;
                free_next    = 4'd8;
                bytes_next   = bytes_inc[15:0];
            end else begin
                partial_next = fill;
                free_next    = left;
            end
        end

        if (cmd.trail_en && out_free) begin
            push       = 1'b1;
            olast_next = 1'b1;
            odone_next = 1'b1;
            if (!limit_hit) begin
                obyte_next   = partial_reg | (8'd1 << (free_reg - 4'd1));
                ovalid_next  = 1'b1;
                ocount_next  = bytes_inc[15:0];
                bytes_next   = bytes_inc[15:0];
                partial_next = 8'd0;
                free_next    = 4'd8;
            end else begin
                obyte_next  = 8'd0;
                ovalid_next = 1'b0;
                ocount_next = bytes_reg;
            end
        end

        m_valid_next = push ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= 16'hFFFF;
            partial_reg <= 8'd0;
            free_reg    <= 4'd8;
            bytes_reg   <= 16'd0;
            zcnt_reg    <= 6'd0;
            dcnt_reg    <= 6'd0;
            len_reg     <= 6'd32;
            m_valid_reg <= 1'b0;
        end else begin
            limit_reg   <= limit_next;
            partial_reg <= partial_next;
            free_reg    <= free_next;
            bytes_reg   <= bytes_next;
            zcnt_reg    <= zcnt_next;
            dcnt_reg    <= dcnt_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg   <= data_next;
        obyte_reg  <= obyte_next;
        ovalid_reg <= ovalid_next;
        olast_reg  <= olast_next;
        odone_reg  <= odone_next;
        ocount_reg <= ocount_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {ocount_reg, obyte_reg};
    assign m_tuser  = {odone_reg, ovalid_reg};
    assign m_tlast  = olast_reg;

endmodule

/* sv/exp_golomb_bitstream_writer.sv */
// Top level of the Exp-Golomb bitstream writer: controller plus datapath.
// Depends on egbw_pkg, egbw_ctrl, egbw_dp and assert_macros.svh.
//
//  Channel | Dir | tdata, low bits first               | tuser / tlast
//  s_      | in  | bit_count, value, signed_value, pad | kind / unused
//  m_      | out | out_byte, unit_bytes                | byte_valid, unit_done / last_in_run
//  cfg_wr_ | in  | cfg_wr_data = byte_limit            | written while cfg_wr_en is high
//
// A start request clears the unit when it is accepted; trailing bits are written from
// the trail state. Other requests are accepted, pass a leading-zero search for ue and se
// codes, then pack one step per cycle while the output can take a byte, each moving as
// many bits as fit into the partial byte (at most ten steps for 63 bits), and a final
// check sees that no bits remain. Packing and trailing bits wait while the output register is full and not taken.
// Reset is synchronous on aresetn low and restores the byte limit to 65535.
`include "assert_macros.svh"

module exp_golomb_bitstream_writer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: byte_limit
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // Input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // bit_count[5:0], value[37:6], signed_value[69:38], zero
    input  logic [2:0]  s_tuser,   // kind[2:0]
    // Result bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte[7:0], unit_bytes[23:8]
    output logic [1:0]  m_tuser,   // byte_valid[0], unit_done[1]
    output logic        m_tlast    // last_in_run
);

    egbw_pkg::dp_cmd_t cmd;
    egbw_pkg::dp_sts_t sts;

    // Datapath operations the controller can command, gathered for checking.
    logic [5:0] cmd_ops;
    // The byte field of the output reads as zero.
    logic       m_byte_zero;

    // The controller only decodes the kind; all payload goes to the datapath,
    // which captures it in the same cycle as the request is accepted.
    egbw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    egbw_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .bit_count    (s_tdata[5:0]),
        .value        (s_tdata[37:6]),
        .signed_value (s_tdata[69:38]),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    assign cmd_ops     = {cmd.clr_unit, cmd.load_fixed, cmd.load_code,
                          cmd.norm_en, cmd.emit_en, cmd.trail_en};
    assign m_byte_zero = (m_tdata[7:0] == 8'd0);

    // Only one datapath operation is ever commanded in a cycle.
    `ASSERT_ALWAYS(a_one_cmd, aclk, aresetn, $onehot0(cmd_ops))
    // A unit report always closes the run of its request.
    `ASSERT_IMPLY(a_done_last, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast)
    // A suppressed byte only appears on a unit report, and reads as zero.
    `ASSERT_IMPLY(a_invalid_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tuser[1] && m_byte_zero)

endmodule

/* tb/exp_golomb_bitstream_writer_tb.sv */
// Self-checking testbench for the Exp-Golomb bitstream writer top level.
// Depends on egbw_pkg and exp_golomb_bitstream_writer; drives both streams and the byte limit.
module exp_golomb_bitstream_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Kinds 5 to 7 carry no meaning; the block must ignore them.
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    localparam int SETTLE_CYCLES  = 40;     // well past the longest request latency
    localparam int MAX_BYTES_PER_REQUEST = 9;
    localparam int REPORT_LIMIT   = 10;

    // One result as it leaves the m_ stream.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_in_run;
        logic        unit_done;
        logic [15:0] unit_bytes;
    } byte_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;      // bit_count[5:0], value[37:6], signed_value[69:38], zero
    logic [2:0]  s_tuser = '0;      // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // out_byte[7:0], unit_bytes[23:8]
    logic [1:0]  m_tuser;           // byte_valid[0], unit_done[1]
    logic        m_tlast;           // last_in_run

    exp_golomb_bitstream_writer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Shadow of the writer state. It starts at the reset values, and reset
    // is only applied once, at time zero.
    logic [7:0]   acc_byte = 8'd0;      // partial byte, filled from the MSB down
    int unsigned  acc_free = 8;         // free bit slots left in the partial byte
    logic [15:0]  acc_count = 16'd0;    // bytes emitted in the current unit
    logic [15:0]  limit_reg = 16'hFFFF; // byte_limit as last written

    byte_result_t step_results[$];      // results of the request being predicted
    byte_result_t expected_bytes[$];    // results still owed by the block, oldest first

    int mismatch_count = 0;

    // Sender burst bookkeeping.
    int burst_left = 0;
    int gap_cycles = 0;

    // Receiver stall pattern.
    int stall_mode = 0;
    int mode_left = 0;
    int stall_left = 0;

    byte_result_t seen_result;
    byte_result_t want_result;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Appends one bit. Returns 1 when it completed a byte. Once the unit has
    // reached its byte limit every bit is dropped on the floor.
    function automatic bit pack_bit(logic b, bit report);
        byte_result_t r;
        if (acc_count >= limit_reg)
            return 1'b0;
        acc_byte[acc_free - 1] = b;
        acc_free--;
        if (acc_free == 0) begin
            r = '0;
            r.out_byte = acc_byte;
            r.byte_valid = 1'b1;
            acc_count++;
            acc_byte = 8'd0;
            acc_free = 8;
            if (report && step_results.size() < MAX_BYTES_PER_REQUEST)
                step_results.push_back(r);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Writes the low n bits of v, most significant first.
    function automatic void pack_field(int n, logic [63:0] v);
        for (int i = n - 1; i >= 0; i--)
            void'(pack_bit(v[i], 1'b1));
    endfunction

    // ue(v): leading zeros, then v+1 in its own bit length. An all-ones v
    // wraps to zero and writes nothing.
    function automatic void pack_ue(logic [31:0] v);
        logic [31:0] code;
        logic [31:0] t;
        int len;
        code = v + 32'd1;
        t = code;
        len = 0;
        while (t != 0) begin
            len++;
            t = t >> 1;
        end
        if (len == 0)
            return;
        pack_field(len - 1, 64'd0);
        pack_field(len, {32'd0, code});
    endfunction

    // Works out every result one accepted request causes and queues them.
    function automatic void predict_request(logic [2:0] kind, logic [5:0] count,
                                            logic [31:0] value, logic [31:0] sval);
        logic [31:0] mapped;
        logic [7:0]  snap_byte;
        int unsigned snap_free;
        bit got;
        byte_result_t r;
        step_results.delete();
        case (kind)
            egbw_pkg::KIND_START: begin
                acc_byte = 8'd0;
                acc_free = 8;
                acc_count = 16'd0;
            end
            egbw_pkg::KIND_FIXED: begin
                pack_field(count, {32'd0, value});
            end
            egbw_pkg::KIND_UE: begin
                pack_ue(value);
            end
            egbw_pkg::KIND_SE: begin
                // Positive v maps to 2v-1, zero and negative v to -2v, all
                // in 32 bits, so the most negative value maps to zero.
                if (sval != 32'd0 && !sval[31])
                    mapped = (sval << 1) - 32'd1;
                else
                    mapped = 32'd0 - (sval << 1);
                pack_ue(mapped);
            end
            egbw_pkg::KIND_TRAIL: begin
                snap_byte = acc_byte;
                snap_free = acc_free;
                got = pack_bit(1'b1, 1'b0);
                if (!got && acc_count < limit_reg) begin
                    while (acc_free != 8 && !got)
                        got = pack_bit(1'b0, 1'b0);
                end
                r = '0;
                if (got) begin
                    r.out_byte = snap_byte | (8'd1 << (snap_free - 1));
                    r.byte_valid = 1'b1;
                end
                r.unit_done = 1'b1;
                r.unit_bytes = acc_count;
                step_results.push_back(r);
            end
            default: begin
            end
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_in_run = 1'b1;
        foreach (step_results[i])
            expected_bytes.push_back(step_results[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offers one request and waits for its handshake. The request is
    // predicted at the edge where it is taken. tvalid stays high into the
    // next request unless a gap between bursts starts here; this way tvalid
    // never gets two updates in the same step.
    task automatic send_request(logic [2:0] kind, logic [5:0] count,
                                logic [31:0] value, logic [31:0] sval);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, sval, value, count};
        s_tuser  <= kind;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_request(kind, count, value, sval);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap_cycles = $urandom_range(0, 6);
            if (gap_cycles > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_cycles) @(posedge aclk);
            end
        end
    endtask

    // Brings the block to rest: no request offered, every owed result taken,
    // then enough cycles for a request that owes nothing to finish too.
    task automatic settle_block();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register writes only happen while the block is at rest.
    task automatic write_byte_limit(logic [15:0] limit);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_reg = limit;
    endtask

    // A random fixed, ue or se request. Fields the kind does not use are
    // still random so that every payload field toggles.
    task automatic send_random_field();
        logic [2:0]  kind;
        logic [5:0]  count;
        logic [31:0] value;
        logic [31:0] sval;
        kind  = 3'($urandom_range(egbw_pkg::KIND_FIXED, egbw_pkg::KIND_SE));
        count = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                            : 6'($urandom_range(0, 32));
        value = $urandom >> $urandom_range(0, 32);
        if ($urandom_range(0, 15) == 0)
            value = 32'hFFFF_FFFF;
        sval = 32'($signed($urandom) >>> $urandom_range(0, 31));
        if ($urandom_range(0, 15) == 0)
            sval = 32'h8000_0000;
        if (kind == egbw_pkg::KIND_FIXED)
            value = $urandom;
        send_request(kind, count, value, sval);
    endtask

    // Fixed fields: zero width, single bit, full 32 bits, and widths past 32
    // where zero bits lead the value.
    task automatic test_fixed_fields();
        send_request(egbw_pkg::KIND_START, 6'd0, 32'd0, 32'd0);
        send_request(egbw_pkg::KIND_FIXED, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(egbw_pkg::KIND_FIXED, 6'd1, 32'd1, 32'd0);
        send_request(egbw_pkg::KIND_FIXED, 6'd32, 32'hFFFF_FFFF, 32'd0);
        send_request(egbw_pkg::KIND_FIXED, 6'd63, 32'hA5C3_0F96, 32'd0);
        send_request(egbw_pkg::KIND_TRAIL, 6'd0, 32'd0, 32'd0);
    endtask

    // ue and se codes at the edges of their ranges, including the all-ones
    // ue value that writes nothing and the most negative se value.
    task automatic test_exp_golomb_codes();
        send_request(egbw_pkg::KIND_START, 6'd0, 32'd0, 32'd0);
        send_request(egbw_pkg::KIND_UE, 6'd0, 32'd0, 32'd0);
        send_request(egbw_pkg::KIND_UE, 6'd0, 32'hFFFF_FFFE, 32'd0);
        send_request(egbw_pkg::KIND_UE, 6'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(egbw_pkg::KIND_SE, 6'd0, 32'd0, 32'd1);
        send_request(egbw_pkg::KIND_SE, 6'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(egbw_pkg::KIND_SE, 6'd0, 32'd0, 32'd0);
        send_request(egbw_pkg::KIND_SE, 6'd0, 32'd0, 32'h7FFF_FFFF);
        send_request(egbw_pkg::KIND_SE, 6'd0, 32'd0, 32'h8000_0000);
        send_request(egbw_pkg::KIND_TRAIL, 6'd0, 32'd0, 32'd0);
    endtask

    // Trailing bits on a byte boundary and mid-byte, requests appended after
    // the trailing bits, and a spare kind that must change nothing.
    task automatic test_trailing_bits();
        send_request(egbw_pkg::KIND_START, 6'd0, 32'd0, 32'd0);
        send_request(egbw_pkg::KIND_TRAIL, 6'd0, 32'd0, 32'd0);
        send_request(egbw_pkg::KIND_FIXED, 6'd3, 32'd5, 32'd0);
        send_request(KIND_SPARE_LAST, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(egbw_pkg::KIND_TRAIL, 6'd0, 32'd0, 32'd0);
    endtask

    // A zero limit suppresses everything, including the trailing byte. A limit
    // lowered below the bytes already emitted drops all later bits.
    task automatic test_byte_limit();
        write_byte_limit(16'd0);
        send_request(egbw_pkg::KIND_START, 6'd0, 32'd0, 32'd0);
        send_request(egbw_pkg::KIND_FIXED, 6'd16, 32'h1234_5678, 32'd0);
        send_request(egbw_pkg::KIND_TRAIL, 6'd0, 32'd0, 32'd0);
        write_byte_limit(16'hFFFF);
        send_request(egbw_pkg::KIND_START, 6'd0, 32'd0, 32'd0);
        send_request(egbw_pkg::KIND_FIXED, 6'd20, 32'h000A_BCDE, 32'd0);
        write_byte_limit(16'd1);
        send_request(egbw_pkg::KIND_FIXED, 6'd8, 32'hFF, 32'd0);
        send_request(egbw_pkg::KIND_TRAIL, 6'd0, 32'd0, 32'd0);
    endtask

    // Random traffic over several byte limits. Most of it is well-formed
    // units (start, a few fields, trailing bits); the rest is single requests
    // of any kind with fully random fields. Ignored kinds are not counted.
    task automatic test_random_stream();
        logic [15:0] phase_limit[6];
        int sent;
        int body_len;
        logic [2:0] kind;
        phase_limit[0] = 16'hFFFF;
        phase_limit[1] = 16'd1;
        phase_limit[2] = 16'($urandom_range(2, 12));
        phase_limit[3] = 16'd0;
        phase_limit[4] = 16'($urandom_range(0, 65535));
        phase_limit[5] = 16'hFFFF;
        foreach (phase_limit[p]) begin
            write_byte_limit(phase_limit[p]);
            sent = 0;
            while (sent < 22) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_request(egbw_pkg::KIND_START, 6'($urandom), $urandom, $urandom);
                    body_len = $urandom_range(1, 6);
                    repeat (body_len) send_random_field();
                    send_request(egbw_pkg::KIND_TRAIL, 6'($urandom), $urandom, $urandom);
                    sent += body_len + 2;
                end else begin
                    kind = 3'($urandom_range(egbw_pkg::KIND_START, KIND_SPARE_LAST));
                    send_request(kind, 6'($urandom), $urandom, $urandom);
                    if (kind < KIND_SPARE_FIRST)
                        sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // m_tready follows a pattern of its own: always ready, randomly ready
    // three times in four, or mostly ready with random stalls.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, 8);
                end
            end
        endcase
    end

    // Every result taken is matched against the oldest owed result. Values
    // read here are the ones from before this edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.out_byte    = m_tdata[7:0];
            seen_result.unit_bytes  = m_tdata[23:8];
            seen_result.byte_valid  = m_tuser[0];
            seen_result.unit_done   = m_tuser[1];
            seen_result.last_in_run = m_tlast;
            if (expected_bytes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result with none owed: ",
                             "byte %02h valid %b last %b done %b count %0d",
                             $time, seen_result.out_byte, seen_result.byte_valid,
                             seen_result.last_in_run, seen_result.unit_done,
                             seen_result.unit_bytes);
            end else begin
                want_result = expected_bytes.pop_front();
                if (seen_result !== want_result) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result mismatch: byte %02h/%02h valid %b/%b ",
                                 "last %b/%b done %b/%b count %0d/%0d (expected/actual)",
                                 $time, want_result.out_byte, seen_result.out_byte,
                                 want_result.byte_valid, seen_result.byte_valid,
                                 want_result.last_in_run, seen_result.last_in_run,
                                 want_result.unit_done, seen_result.unit_done,
                                 want_result.unit_bytes, seen_result.unit_bytes);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fixed_fields();
        test_exp_golomb_codes();
        test_trailing_bits();
        test_byte_limit();
        test_random_stream();
        settle_block();
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("PASS exp_golomb_bitstream_writer");
        else
            $display("FAIL exp_golomb_bitstream_writer");
        $finish;
    end

    // Generous bound: the slowest correct run stays far below 5 ms.
    initial begin
        #5_000_000;
        $display("FAIL exp_golomb_bitstream_writer");
        $finish;
    end

endmodule
